>>> hw/rtl/gss_pkg.sv
// Shared constants and types for the Gray-Scott grid step core.
// No dependencies; compile first.
package gss_pkg;

  localparam int GRID_W     = 256;
  localparam int GRID_H     = 256;
  localparam int X_W        = $clog2(GRID_W);
  localparam int Y_W        = $clog2(GRID_H);
  localparam int CELL_W     = X_W + Y_W;
  localparam int CONC_W     = 16;
  localparam int COORD_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_Q14   = 14;
  localparam int FRAC_Q15   = 15;
  localparam logic [CONC_W-1:0] ONE_Q15 = 16'd32768;

  // Operation codes of the input word
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Reply codes of the result word
  localparam logic [1:0] RK_WRITE = 2'd0;
  localparam logic [1:0] RK_STEP  = 2'd1;
  localparam logic [1:0] RK_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_U = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_V = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KILL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DT     = 3'd4;

  // One grid entry: v in the upper half, u in the lower half
  typedef struct packed {
    logic [CONC_W-1:0] v;
    logic [CONC_W-1:0] u;
  } cell_t;

endpackage

>>> hw/rtl/gss_in_if.sv
// Input channel of the Gray-Scott grid step core: valid/ready plus one command word.
// Depends on gss_pkg.
interface gss_in_if import gss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [COORD_W-1:0] cell_x;
  logic [COORD_W-1:0] cell_y;
  logic [CONC_W-1:0]  u_in;
  logic [CONC_W-1:0]  v_in;

  modport source (output valid, operation, cell_x, cell_y, u_in, v_in, input ready);
  modport sink   (input valid, operation, cell_x, cell_y, u_in, v_in, output ready);
endinterface

>>> hw/rtl/gss_out_if.sv
// Result channel of the Gray-Scott grid step core: valid/ready plus one reply word.
// Depends on gss_pkg.
interface gss_out_if import gss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        reply_kind;
  logic [CONC_W-1:0] u_out;
  logic [CONC_W-1:0] v_out;

  modport source (output valid, reply_kind, u_out, v_out, input ready);
  modport sink   (input valid, reply_kind, u_out, v_out, output ready);
endinterface

>>> hw/rtl/gray_scott_grid_step_core.sv
// Gray-Scott grid step core: two ping-pong grid memories and the per-cell update sequencer.
// Depends on gss_pkg, gss_in_if and gss_out_if.
//
// Holds a wrapping 256 x 256 grid of u and v (Q1.15) in two memories used in turn. A write
// word stores one cell and is acknowledged at once; a read word returns the cell by way of
// the memory read register and the output register. A step word sweeps every cell: five
// reads from the live memory's single read port (centre and four neighbours), four arithmetic
// stages and one write-back to the other memory, after which the live memory swaps and a
// done word is sent. One word is in work at a time; the next is taken once the previous
// reply has left or is leaving. Every cell must be written before the first step or read.
module gray_scott_grid_step_core import gss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  gss_in_if.sink                in_ch,
  gss_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_RDATA, S_FETCH, S_M1, S_M2, S_M3, S_M4, S_WB
  } state_t;

  state_t state_r;

  // Grid memories
  cell_t mem_a [GRID_W*GRID_H];
  cell_t mem_b [GRID_W*GRID_H];
  cell_t rd_a_r, rd_b_r, rd_data;
  logic  we_a, we_b;
  logic [CELL_W-1:0] rd_addr, wr_addr;
  cell_t wr_data;

  // Configuration
  logic [CONC_W-1:0] du_r, dv_r, fr_r, kr_r, dt_r;
  logic cur_b_r;

  // Sweep position and neighbour fetch
  logic [X_W-1:0] cx_r;
  logic [Y_W-1:0] cy_r;
  logic [2:0]     nb_r;
  logic [CONC_W-1:0] cu_r, cv_r;
  logic [CONC_W+1:0] sum_u_r, sum_v_r;

  // Arithmetic pipeline registers
  logic signed [35:0] prod_u_r, prod_v_r;
  logic [31:0] uv_r;
  logic [32:0] feed_r, fk_r;
  logic [CONC_W-1:0] uvv_r;
  logic signed [21:0] tu_r, tv_r;
  logic [18:0] f1_r, fk1_r;
  logic signed [22:0] dnu_r, dnv_r;
  logic signed [39:0] pdu_r, pdv_r;

  // Output register
  logic              out_valid_r;
  logic [1:0]        out_kind_r;
  logic [CONC_W-1:0] out_u_r, out_v_r;

  logic in_fire, last_cell, out_load;
  logic [X_W-1:0] xm, xp;
  logic [Y_W-1:0] ym, yp;
  logic signed [18:0] lap_u, lap_v;
  logic signed [35:0] pu_adj, pv_adj;
  logic signed [39:0] pdu_adj, pdv_adj;
  logic signed [26:0] nu_full, nv_full;
  logic [CONC_W-1:0] nu, nv, sat_u, sat_v;
  logic [32:0] uvv_full;

  assign in_ch.ready       = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire           = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.reply_kind = out_kind_r;
  assign out_ch.u_out      = out_u_r;
  assign out_ch.v_out      = out_v_r;

  assign last_cell = (cx_r == X_W'(GRID_W-1)) && (cy_r == Y_W'(GRID_H-1));
  assign rd_data   = cur_b_r ? rd_b_r : rd_a_r;

  // A new reply word is loaded this cycle
  assign out_load = (in_fire && in_ch.operation == OP_WRITE) || (state_r == S_RDATA) ||
                    (state_r == S_WB && last_cell);

  // Wrap neighbour coordinates round the torus
  assign xm = (cx_r == '0) ? X_W'(GRID_W-1) : X_W'(cx_r - 1'b1);
  assign xp = (cx_r == X_W'(GRID_W-1)) ? '0 : X_W'(cx_r + 1'b1);
  assign ym = (cy_r == '0) ? Y_W'(GRID_H-1) : Y_W'(cy_r - 1'b1);
  assign yp = (cy_r == Y_W'(GRID_H-1)) ? '0 : Y_W'(cy_r + 1'b1);

  // Saturate write data to one
  assign sat_u = (in_ch.u_in > ONE_Q15) ? ONE_Q15 : in_ch.u_in;
  assign sat_v = (in_ch.v_in > ONE_Q15) ? ONE_Q15 : in_ch.v_in;

  // Laplacians from the accumulated neighbours
  assign lap_u = $signed({1'b0, sum_u_r}) - $signed({1'b0, cu_r, 2'b00});
  assign lap_v = $signed({1'b0, sum_v_r}) - $signed({1'b0, cv_r, 2'b00});

  // Truncate Q14 products toward zero
  assign pu_adj  = prod_u_r + $signed({22'd0, {FRAC_Q14{prod_u_r[35]}}});
  assign pv_adj  = prod_v_r + $signed({22'd0, {FRAC_Q14{prod_v_r[35]}}});
  assign pdu_adj = pdu_r + $signed({26'd0, {FRAC_Q14{pdu_r[39]}}});
  assign pdv_adj = pdv_r + $signed({26'd0, {FRAC_Q14{pdv_r[39]}}});

  assign uvv_full = 33'(uv_r >> FRAC_Q15) * 33'(cv_r);

  // New values, clamped to [0, one]
  assign nu_full = $signed({11'd0, cu_r}) + 27'($signed(pdu_adj[39:14]));
  assign nv_full = $signed({11'd0, cv_r}) + 27'($signed(pdv_adj[39:14]));
  assign nu = nu_full[26] ? '0 : ((nu_full > 27'sd32768) ? ONE_Q15 : nu_full[CONC_W-1:0]);
  assign nv = nv_full[26] ? '0 : ((nv_full > 27'sd32768) ? ONE_Q15 : nv_full[CONC_W-1:0]);

  // Steer memory addresses and write enables
  always_comb begin
    rd_addr = {Y_W'(in_ch.cell_y), X_W'(in_ch.cell_x)};
    wr_addr = {Y_W'(in_ch.cell_y), X_W'(in_ch.cell_x)};
    wr_data = '{v: sat_v, u: sat_u};
    we_a    = 1'b0;
    we_b    = 1'b0;
    if (state_r == S_FETCH) begin
      case (nb_r)
        3'd0:    rd_addr = {cy_r, cx_r};
        3'd1:    rd_addr = {cy_r, xm};
        3'd2:    rd_addr = {cy_r, xp};
        3'd3:    rd_addr = {ym, cx_r};
        default: rd_addr = {yp, cx_r};
      endcase
    end
    if (in_fire && in_ch.operation == OP_WRITE) begin
      we_a = !cur_b_r;
      we_b = cur_b_r;
    end else if (state_r == S_WB) begin
      wr_addr = {cy_r, cx_r};
      wr_data = '{v: nv, u: nu};
      we_a    = cur_b_r;
      we_b    = !cur_b_r;
    end
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    rd_a_r <= mem_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    rd_b_r <= mem_b[rd_addr];
  end

  // Sequencer, configuration and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cur_b_r     <= 1'b0;
      du_r        <= 16'd3277;
      dv_r        <= 16'd1638;
      fr_r        <= 16'd901;
      kr_r        <= 16'd1016;
      dt_r        <= 16'd16384;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DIFF_U: du_r <= cfg_data;
          REG_DIFF_V: dv_r <= cfg_data;
          REG_FEED:   fr_r <= cfg_data;
          REG_KILL:   kr_r <= cfg_data;
          REG_DT:     dt_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (in_ch.operation)
              OP_WRITE: begin
                out_valid_r <= 1'b1;
                out_kind_r  <= RK_WRITE;
                out_u_r     <= '0;
                out_v_r     <= '0;
              end
              OP_STEP: begin
                cx_r    <= '0;
                cy_r    <= '0;
                nb_r    <= '0;
                sum_u_r <= '0;
                sum_v_r <= '0;
                state_r <= S_FETCH;
              end
              default: state_r <= S_RDATA;
            endcase
          end
        end
        S_RDATA: begin
          out_valid_r <= 1'b1;
          out_kind_r  <= RK_READ;
          out_u_r     <= rd_data.u;
          out_v_r     <= rd_data.v;
          state_r     <= S_IDLE;
        end
        S_FETCH: begin
          // Take the word from the memory read register
          if (nb_r == 3'd1) begin
            cu_r <= rd_data.u;
            cv_r <= rd_data.v;
          end else if (nb_r != 3'd0) begin
            sum_u_r <= sum_u_r + 18'(rd_data.u);
            sum_v_r <= sum_v_r + 18'(rd_data.v);
          end
          if (nb_r == 3'd5) begin
            state_r <= S_M1;
          end else begin
            nb_r <= nb_r + 3'd1;
          end
        end
        S_M1: begin
          prod_u_r <= $signed({1'b0, du_r}) * lap_u;
          prod_v_r <= $signed({1'b0, dv_r}) * lap_v;
          uv_r     <= cu_r * cv_r;
          feed_r   <= 33'(fr_r) * 33'(17'(ONE_Q15) - {1'b0, cu_r});
          fk_r     <= 33'({1'b0, fr_r} + {1'b0, kr_r}) * 33'(cv_r);
          state_r  <= S_M2;
        end
        S_M2: begin
          uvv_r   <= uvv_full[30:15];
          tu_r    <= pu_adj[35:14];
          tv_r    <= pv_adj[35:14];
          f1_r    <= feed_r[32:14];
          fk1_r   <= fk_r[32:14];
          state_r <= S_M3;
        end
        S_M3: begin
          dnu_r   <= 23'(tu_r) - $signed({7'd0, uvv_r}) + $signed({4'd0, f1_r});
          dnv_r   <= 23'(tv_r) + $signed({7'd0, uvv_r}) - $signed({4'd0, fk1_r});
          state_r <= S_M4;
        end
        S_M4: begin
          pdu_r   <= dnu_r * $signed({1'b0, dt_r});
          pdv_r   <= dnv_r * $signed({1'b0, dt_r});
          state_r <= S_WB;
        end
        S_WB: begin
          // Advance to the next cell, or finish and swap grids
          if (last_cell) begin
            cur_b_r     <= !cur_b_r;
            out_valid_r <= 1'b1;
            out_kind_r  <= RK_STEP;
            out_u_r     <= '0;
            out_v_r     <= '0;
            state_r     <= S_IDLE;
          end else begin
            if (cx_r == X_W'(GRID_W-1)) begin
              cx_r <= '0;
              cy_r <= Y_W'(cy_r + 1'b1);
            end else begin
              cx_r <= X_W'(cx_r + 1'b1);
            end
            nb_r    <= '0;
            sum_u_r <= '0;
            sum_v_r <= '0;
            state_r <= S_FETCH;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_swap_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_b_r != $past(cur_b_r)) |-> (out_valid_r && out_kind_r == RK_STEP))
    else $error("grid swap without step reply");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(we_a && we_b))
    else $error("both grids written in one cycle");

  a_fetch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH) |-> (nb_r <= 3'd5))
    else $error("neighbour counter overran");

  a_wb_to_dst: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |-> (we_a == cur_b_r && we_b == !cur_b_r))
    else $error("write-back aimed at live grid");
`endif

endmodule
